@@ src/swept_sphere_plane_collision_defines.svh @@
// Assertion macros used by the collision block's checker.
// Include this header by its bare file name; it depends on nothing else.
`ifndef SWEPT_SPHERE_PLANE_COLLISION_DEFINES_SVH
`define SWEPT_SPHERE_PLANE_COLLISION_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SSP_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("ssp assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define SSP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("ssp assertion failed");

`endif

@@ src/ssp_pkg.sv @@
// Types and constants of the swept sphere against plane collision block.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
package ssp_pkg;

  localparam int ONE_Q      = 65536;
  localparam int DIV_STAGES = 32;
  localparam int Q_DEPTH    = 4;

  typedef logic signed [31:0] coord_t;
  typedef logic signed [32:0] delta_t;
  typedef logic signed [17:0] nrm_t;
  typedef logic signed [36:0] dot_t;
  typedef logic signed [53:0] num_t;
  typedef logic [30:0]        radius_t;

  typedef enum logic [2:0] {
    REG_NORMAL_X = 3'd0,
    REG_NORMAL_Y = 3'd1,
    REG_NORMAL_Z = 3'd2,
    REG_ANCHOR_X = 3'd3,
    REG_ANCHOR_Y = 3'd4,
    REG_ANCHOR_Z = 3'd5,
    REG_RADIUS   = 3'd6
  } reg_idx_e;

  typedef enum logic [1:0] {
    OUT_MISS      = 2'd0,
    OUT_PARALLEL  = 2'd1,
    OUT_PENETRATE = 2'd2,
    OUT_SWEPT     = 2'd3
  } outcome_e;

  typedef enum logic [2:0] {
    NRM_IDLE,
    NRM_SQUARE,
    NRM_ROOT,
    NRM_DIVIDE,
    NRM_PUSH
  } nrm_state_e;

  typedef struct packed {
    coord_t [2:0] anchor;
    radius_t      radius;
    nrm_t   [2:0] nrm;
    coord_t [2:0] push;
  } plane_t;

  typedef struct packed {
    coord_t [2:0] prev;
    delta_t [2:0] delta;
    num_t         num;
    dot_t         vel;
    logic         par;
    logic         pen;
    logic         vneg;
  } qent_t;

endpackage

@@ src/ssp_cfg.sv @@
// Register file and normal normalizer of the collision block.
// Squares, takes the integer root, divides bit-serially and forms the push vector; depends on ssp_pkg.
`timescale 1ns / 1ps
module ssp_cfg (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [4:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready,
  output ssp_pkg::plane_t plane_o,
  output logic            busy_o
);
  import ssp_pkg::*;

  coord_t [2:0] norm_q;
  coord_t [2:0] anchor_q;
  radius_t      radius_q;
  nrm_t   [2:0] nrm_q;
  coord_t [2:0] push_q;

  nrm_state_e  state_q, state_d;
  logic [1:0]  comp_q;
  logic [4:0]  cnt_q;
  logic [63:0] acc_q;
  logic [63:0] root_q;
  logic [63:0] res_q;
  logic [31:0] drem_q;
  logic [15:0] quo_q;

  reg_idx_e          wr_idx;
  logic              wr_en;
  logic              start;
  logic [31:0]       mag;
  logic [63:0]       sq;
  logic [63:0]       bitv;
  logic [64:0]       trial;
  logic              root_ge;
  logic [31:0]       len;
  logic              first_ge;
  logic [32:0]       rem2;
  logic              div_ge;
  logic [16:0]       quo_fin;
  nrm_t              nrm_fin;
  logic signed [48:0] push_prod;

  assign pready = 1'b1;
  assign wr_idx = reg_idx_e'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;
  assign start  = wr_en && (wr_idx == REG_NORMAL_X || wr_idx == REG_NORMAL_Y ||
                            wr_idx == REG_NORMAL_Z || wr_idx == REG_RADIUS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      norm_q   <= {coord_t'(ONE_Q), coord_t'(0), coord_t'(0)};
      anchor_q <= '0;
      radius_q <= radius_t'(ONE_Q);
    end else if (wr_en) begin
      case (wr_idx)
        REG_NORMAL_X: norm_q[0]   <= pwdata;
        REG_NORMAL_Y: norm_q[1]   <= pwdata;
        REG_NORMAL_Z: norm_q[2]   <= pwdata;
        REG_ANCHOR_X: anchor_q[0] <= pwdata;
        REG_ANCHOR_Y: anchor_q[1] <= pwdata;
        REG_ANCHOR_Z: anchor_q[2] <= pwdata;
        REG_RADIUS:   radius_q    <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (wr_idx)
      REG_NORMAL_X: prdata = norm_q[0];
      REG_NORMAL_Y: prdata = norm_q[1];
      REG_NORMAL_Z: prdata = norm_q[2];
      REG_ANCHOR_X: prdata = anchor_q[0];
      REG_ANCHOR_Y: prdata = anchor_q[1];
      REG_ANCHOR_Z: prdata = anchor_q[2];
      REG_RADIUS:   prdata = {1'b0, radius_q};
      default:      prdata = '0;
    endcase
  end

  always_comb begin
    mag       = norm_q[comp_q][31] ? 32'(-norm_q[comp_q]) : 32'(norm_q[comp_q]);
    sq        = mag * mag;
    bitv      = 64'd1 << (6'd62 - {cnt_q, 1'b0});
    trial     = {1'b0, res_q} + {1'b0, bitv};
    root_ge   = {1'b0, root_q} >= trial;
    len       = res_q[31:0];
    first_ge  = mag >= len;
    rem2      = {drem_q, 1'b0};
    div_ge    = rem2 >= {1'b0, len};
    quo_fin   = {quo_q, div_ge};
    if (len == '0) begin
      nrm_fin = '0;
    end else if (norm_q[comp_q][31]) begin
      nrm_fin = -nrm_t'({1'b0, quo_fin});
    end else begin
      nrm_fin = nrm_t'({1'b0, quo_fin});
    end
    push_prod = nrm_q[comp_q] * $signed({1'b0, radius_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= NRM_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    busy_o  = (state_q != NRM_IDLE);
    case (state_q)
      NRM_IDLE:   state_d = NRM_IDLE;
      NRM_SQUARE: if (comp_q == 2'd2) state_d = NRM_ROOT;
      NRM_ROOT:   if (cnt_q == 5'd31) state_d = NRM_DIVIDE;
      NRM_DIVIDE: if (cnt_q == 5'd16 && comp_q == 2'd2) state_d = NRM_PUSH;
      NRM_PUSH:   if (comp_q == 2'd2) state_d = NRM_IDLE;
      default:    state_d = NRM_IDLE;
    endcase
    if (start) begin
      state_d = NRM_SQUARE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      comp_q <= '0;
      cnt_q  <= '0;
      acc_q  <= '0;
      root_q <= '0;
      res_q  <= '0;
      drem_q <= '0;
      quo_q  <= '0;
      nrm_q  <= {nrm_t'(ONE_Q), nrm_t'(0), nrm_t'(0)};
      push_q <= {coord_t'(ONE_Q), coord_t'(0), coord_t'(0)};
    end else if (start) begin
      comp_q <= '0;
      cnt_q  <= '0;
      acc_q  <= '0;
    end else begin
      case (state_q)
        NRM_SQUARE: begin
          acc_q <= acc_q + sq;
          if (comp_q == 2'd2) begin
            root_q <= acc_q + sq;
            res_q  <= '0;
            cnt_q  <= '0;
            comp_q <= '0;
          end else begin
            comp_q <= comp_q + 2'd1;
          end
        end
        NRM_ROOT: begin
          if (root_ge) begin
            root_q <= root_q - trial[63:0];
            res_q  <= (res_q >> 1) + bitv;
          end else begin
            res_q  <= res_q >> 1;
          end
          cnt_q <= cnt_q + 5'd1;
        end
        NRM_DIVIDE: begin
          if (cnt_q == 5'd0) begin
            quo_q  <= {15'd0, first_ge};
            drem_q <= first_ge ? mag - len : mag;
            cnt_q  <= cnt_q + 5'd1;
          end else if (cnt_q == 5'd16) begin
            nrm_q[comp_q] <= nrm_fin;
            cnt_q         <= '0;
            comp_q        <= (comp_q == 2'd2) ? 2'd0 : comp_q + 2'd1;
          end else begin
            quo_q  <= quo_fin[15:0];
            drem_q <= div_ge ? 32'(rem2 - {1'b0, len}) : rem2[31:0];
            cnt_q  <= cnt_q + 5'd1;
          end
        end
        NRM_PUSH: begin
          push_q[comp_q] <= push_prod[47:16];
          comp_q         <= (comp_q == 2'd2) ? 2'd0 : comp_q + 2'd1;
        end
        default: ;
      endcase
    end
  end

  assign plane_o.anchor = anchor_q;
  assign plane_o.radius = radius_q;
  assign plane_o.nrm    = nrm_q;
  assign plane_o.push   = push_q;

endmodule

@@ src/ssp_front.sv @@
// Front pipeline: takes input transfers, forms the distance and motion along
// the normal and classifies the query for the back end; depends on ssp_pkg.
`timescale 1ns / 1ps
module ssp_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_tvalid_i,
  output logic            s_tready_o,
  input  logic [191:0]    s_tdata_i,
  input  ssp_pkg::plane_t plane_i,
  input  logic            busy_i,
  input  logic            q_full_i,
  output logic            q_push_o,
  output ssp_pkg::qent_t  q_data_o
);
  import ssp_pkg::*;

  logic en;
  logic v0_q, v1_q, v2_q;
  coord_t [2:0] p0_q, p1_q, p2_q;
  delta_t [2:0] mv0_q, dm0_q, dm1_q, dm2_q;
  logic signed [50:0] pm1_q [3];
  logic signed [50:0] pd1_q [3];
  dot_t d2_q, vel2_q;

  coord_t [2:0] pin, cin;
  logic signed [52:0] sum_m, sum_d;
  logic [36:0] absd;
  logic signed [37:0] rmd;

  assign en         = !q_full_i;
  assign s_tready_o = en && !busy_i;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pin[i] = s_tdata_i[32*i +: 32];
      cin[i] = s_tdata_i[96 + 32*i +: 32];
    end
    sum_m = 53'(pm1_q[0]) + 53'(pm1_q[1]) + 53'(pm1_q[2]);
    sum_d = 53'(pd1_q[0]) + 53'(pd1_q[1]) + 53'(pd1_q[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en) begin
      v0_q <= s_tvalid_i && s_tready_o;
      v1_q <= v0_q;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p0_q[i]  <= pin[i];
        mv0_q[i] <= 33'(pin[i]) - 33'(plane_i.anchor[i]);
        dm0_q[i] <= 33'(cin[i]) - 33'(pin[i]);
        pm1_q[i] <= mv0_q[i] * plane_i.nrm[i];
        pd1_q[i] <= dm0_q[i] * plane_i.nrm[i];
      end
      p1_q   <= p0_q;
      dm1_q  <= dm0_q;
      p2_q   <= p1_q;
      dm2_q  <= dm1_q;
      d2_q   <= sum_m[52:16];
      vel2_q <= sum_d[52:16];
    end
  end

  always_comb begin
    absd          = d2_q[36] ? 37'(-d2_q) : 37'(d2_q);
    rmd           = 38'($signed({1'b0, plane_i.radius})) - 38'(d2_q);
    q_push_o      = en && v2_q;
    q_data_o.prev  = p2_q;
    q_data_o.delta = dm2_q;
    q_data_o.num   = {rmd, 16'd0};
    q_data_o.vel   = vel2_q;
    q_data_o.pen   = absd < {6'd0, plane_i.radius};
    q_data_o.par   = q_data_o.pen && (vel2_q == '0);
    q_data_o.vneg  = vel2_q[36];
  end

endmodule

@@ src/ssp_queue.sv @@
// Short queue between the front and the back of the collision block.
// Holds classified queries so either side can stall alone; depends on ssp_pkg.
`timescale 1ns / 1ps
module ssp_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ssp_pkg::qent_t data_i,
  input  logic           pop_i,
  output ssp_pkg::qent_t data_o,
  output logic           valid_o,
  output logic           full_o
);
  import ssp_pkg::*;

  localparam int PTR_W = $clog2(Q_DEPTH);

  qent_t            mem_q [Q_DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [PTR_W:0]   cnt_q;

  assign data_o  = mem_q[rd_q];
  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == (PTR_W+1)'(Q_DEPTH));

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

@@ src/ssp_back.sv @@
// Back pipeline: divides for the contact time one quotient bit per stage,
// picks the outcome and forms the contact point; depends on ssp_pkg.
`timescale 1ns / 1ps
module ssp_back #(
  parameter int VAL_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  ssp_pkg::qent_t        q_data_i,
  output logic                  q_pop_o,
  input  ssp_pkg::coord_t [2:0] push_i,
  output logic                  m_tvalid_o,
  input  logic                  m_tready_i,
  output logic [223:0]          m_tdata_o,
  output logic [2:0]            m_tuser_o
);
  import ssp_pkg::*;

  localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (VAL_BITS - 1)) - 64'sd1;
  localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;

  typedef struct packed {
    coord_t [2:0] prev;
    delta_t [2:0] delta;
    logic         par;
    logic         pen;
    logic         vneg;
    logic         neg;
    logic         ovf;
    logic [36:0]  vmag;
    logic [53:0]  rem;
    logic [31:0]  quo;
  } div_t;

  function automatic div_t div_step(div_t s, int k);
    logic [68:0] sub;
    div_t        r;
    r   = s;
    sub = {32'd0, s.vmag} << k;
    if ({15'd0, s.rem} >= sub) begin
      r.rem    = s.rem - sub[53:0];
      r.quo[k] = 1'b1;
    end
    return r;
  endfunction

  function automatic coord_t sat_val(logic signed [63:0] x);
    if (x > SAT_HI) begin
      return SAT_HI[31:0];
    end else if (x < SAT_LO) begin
      return SAT_LO[31:0];
    end
    return x[31:0];
  endfunction

  logic en;
  div_t dv_q [DIV_STAGES+1];
  logic [DIV_STAGES:0] dvv_q;
  div_t prep;

  logic         tv_q;
  coord_t       t_q;
  outcome_e     toc_q;
  coord_t [2:0] tp_q;
  delta_t [2:0] td_q;

  logic               mv_q;
  coord_t             mt_q;
  outcome_e           moc_q;
  coord_t [2:0]       mp_q;
  delta_t [2:0]       md_q;
  logic signed [64:0] prod_q [3];

  logic         out_vld_q;
  logic [223:0] tdata_q;
  logic [2:0]   tuser_q;

  div_t               last;
  logic signed [63:0] qs, t64;
  coord_t             t_c;
  outcome_e           oc_c;
  coord_t [2:0]       hp;
  logic signed [63:0] acc;

  assign en         = !out_vld_q || m_tready_i;
  assign q_pop_o    = en && q_valid_i;
  assign m_tvalid_o = out_vld_q;
  assign m_tdata_o  = tdata_q;
  assign m_tuser_o  = tuser_q;

  always_comb begin
    prep.prev  = q_data_i.prev;
    prep.delta = q_data_i.delta;
    prep.par   = q_data_i.par;
    prep.pen   = q_data_i.pen;
    prep.vneg  = q_data_i.vneg;
    prep.rem   = q_data_i.num[53] ? 54'(-q_data_i.num) : 54'(q_data_i.num);
    prep.vmag  = q_data_i.vel[36] ? 37'(-q_data_i.vel) : 37'(q_data_i.vel);
    prep.quo   = '0;
    if (q_data_i.vel == '0) begin
      prep.ovf = 1'b1;
      prep.neg = q_data_i.num[53];
    end else begin
      prep.ovf = {15'd0, prep.rem} >= {prep.vmag, 32'd0};
      prep.neg = q_data_i.num[53] ^ q_data_i.vel[36];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvv_q <= '0;
    end else if (en) begin
      dvv_q <= {dvv_q[DIV_STAGES-1:0], q_pop_o};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_q[0] <= prep;
      for (int j = 0; j < DIV_STAGES; j++) begin
        dv_q[j+1] <= div_step(dv_q[j], DIV_STAGES - 1 - j);
      end
    end
  end

  always_comb begin
    last = dv_q[DIV_STAGES];
    qs   = $signed({32'd0, last.quo});
    if (!last.neg) begin
      t64 = (last.ovf || qs > SAT_HI) ? SAT_HI : qs;
    end else begin
      t64 = (last.ovf || qs > -SAT_LO) ? SAT_LO : -qs;
    end
    t_c  = t64[31:0];
    oc_c = OUT_MISS;
    if (last.par) begin
      oc_c = OUT_PARALLEL;
      t_c  = SAT_HI[31:0];
    end else if (last.pen) begin
      oc_c = OUT_PENETRATE;
    end else if (last.vneg && !t_c[31] && t_c <= coord_t'(ONE_Q)) begin
      oc_c = OUT_SWEPT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tv_q      <= 1'b0;
      mv_q      <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      tv_q      <= dvv_q[DIV_STAGES];
      mv_q      <= tv_q;
      out_vld_q <= mv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t_q   <= t_c;
      toc_q <= oc_c;
      tp_q  <= last.prev;
      td_q  <= last.delta;
      mt_q  <= t_q;
      moc_q <= toc_q;
      mp_q  <= tp_q;
      md_q  <= td_q;
      for (int i = 0; i < 3; i++) begin
        prod_q[i] <= t_q * td_q[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc = 64'(mp_q[i]);
      if (moc_q == OUT_PENETRATE || moc_q == OUT_SWEPT) begin
        acc = acc + 64'($signed(prod_q[i][64:16]));
      end
      if (moc_q == OUT_SWEPT) begin
        acc = acc + 64'(md_q[i]) + 64'(push_i[i]);
      end
      hp[i] = sat_val(acc);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (moc_q == OUT_MISS) begin
        tdata_q <= '0;
        tuser_q <= '0;
      end else begin
        tdata_q <= {sat_val(64'(push_i[2])), sat_val(64'(push_i[1])),
                    sat_val(64'(push_i[0])), hp[2], hp[1], hp[0], mt_q};
        tuser_q <= {moc_q, 1'b1};
      end
    end
  end

endmodule

@@ src/swept_sphere_plane_collision.sv @@
// Throughput: one query per cycle while neither a normal update, a full queue nor an
// output stall holds input off, as the front, the queue and the back are fully pipelined.
// A write of a normal or radius register holds off input while the normal
// is squared, rooted and divided bit-serially and the push vector is formed.
// Reset (rst_ni, asynchronous, active low) loads the register defaults and
// empties every pipeline stage and the queue.
`timescale 1ns / 1ps
module swept_sphere_plane_collision #(
  parameter int COORD_BITS = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // previous_x, previous_y, previous_z, current_x, current_y, current_z
  input  logic [191:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // hit_time, hit_x, hit_y, hit_z, push_x, push_y, push_z
  output logic [223:0] m_axis_tdata,
  // hit, outcome
  output logic [2:0]   m_axis_tuser,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import ssp_pkg::*;

  localparam int VAL_BITS = (COORD_BITS < 32) ? COORD_BITS : 32;

  plane_t plane;
  logic   busy;
  logic   q_push, q_pop, q_valid, q_full;
  qent_t  q_in, q_out;

  ssp_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .plane_o (plane),
    .busy_o  (busy)
  );

  ssp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .plane_i    (plane),
    .busy_i     (busy),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_in)
  );

  ssp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .pop_i   (q_pop),
    .data_o  (q_out),
    .valid_o (q_valid),
    .full_o  (q_full)
  );

  ssp_back #(
    .VAL_BITS (VAL_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_data_i   (q_out),
    .q_pop_o    (q_pop),
    .push_i     (plane.push),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata),
    .m_tuser_o  (m_axis_tuser)
  );

endmodule

@@ src/ssp_checker.sv @@
// Port-level checks of the collision block, bound to its top level.
// Depends on ssp_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "swept_sphere_plane_collision_defines.svh"
module ssp_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [223:0] m_axis_tdata,
  input logic [2:0]   m_axis_tuser,
  input logic         psel,
  input logic         penable,
  input logic         pwrite,
  input logic [4:0]   paddr
);
  import ssp_pkg::*;

  logic norm_wr;

  assign norm_wr = psel && penable && pwrite &&
                   (paddr[4:2] == REG_NORMAL_X || paddr[4:2] == REG_NORMAL_Y ||
                    paddr[4:2] == REG_NORMAL_Z || paddr[4:2] == REG_RADIUS);

  `SSP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
  `SSP_ASSERT_NOW(a_hit_kind, clk_i, rst_ni, m_axis_tvalid, m_axis_tuser[0] == (m_axis_tuser[2:1] != OUT_MISS))
  `SSP_ASSERT_NOW(a_miss_zero, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata == '0)
  `SSP_ASSERT_NOW(a_swept_time, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[2:1] == OUT_SWEPT, !m_axis_tdata[31] && m_axis_tdata[31:0] <= 32'(ONE_Q))
  `SSP_ASSERT_NEXT(a_norm_busy, clk_i, rst_ni, norm_wr, !s_axis_tready)

endmodule

bind swept_sphere_plane_collision ssp_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .psel          (psel),
  .penable       (penable),
  .pwrite        (pwrite),
  .paddr         (paddr)
);

@@ bench/tb_swept_sphere_plane_collision.sv @@
// Self-checking testbench for the swept sphere against plane collision block.
// Drives queries over the stream input and plane setups over APB, and checks
// every result against a predictor or a typed row; depends on ssp_pkg and the block.
`timescale 1ns / 1ps
module tb_swept_sphere_plane_collision;
  import ssp_pkg::*;

  localparam longint SAT_MAX = 64'sd2147483647;
  localparam longint SAT_MIN = -64'sd2147483648;
  localparam int     WATCHDOG_LIMIT = 4000;
  localparam int     DRAIN_CYCLES = 60;

  typedef struct {
    coord_t p[3];
    coord_t c[3];
  } query_t;

  typedef struct {
    logic     hit;
    outcome_e kind;
    coord_t   t;
    coord_t   pt[3];
    coord_t   push[3];
  } contact_t;

  typedef struct {
    query_t   q;
    logic     typed;
    contact_t res;
  } dir_row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [191:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [223:0] m_axis_tdata;
  logic [2:0]   m_axis_tuser;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [4:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  longint   plane_n[3];
  longint   plane_a[3];
  longint   plane_r;
  contact_t contact_q[$];
  int       mismatches = 0;
  int       results_seen = 0;
  int       quiet_cycles = 0;

  swept_sphere_plane_collision u_top (.*);

  always #2 clk_i = ~clk_i;

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  function automatic longint unsigned root_floor(longint unsigned a);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > a) b >>= 2;
    while (b != 0) begin
      if (a >= res + b) begin
        a -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic coord_t clamp32(logic signed [127:0] x);
    if (x > SAT_MAX) return coord_t'(SAT_MAX);
    if (x < SAT_MIN) return coord_t'(SAT_MIN);
    return coord_t'(x);
  endfunction

  function automatic contact_t predict_contact(query_t q);
    longint u[3], mv[3], dm[3], push[3];
    longint d, v, t, num, r, mag;
    longint unsigned len, ssum;
    logic signed [127:0] acc;
    contact_t res;
    r = plane_r;
    ssum = 0;
    for (int k = 0; k < 3; k++) begin
      mag = plane_n[k] < 0 ? -plane_n[k] : plane_n[k];
      ssum += longint'(mag) * longint'(mag);
    end
    len = root_floor(ssum);
    d = 0;
    v = 0;
    for (int k = 0; k < 3; k++) begin
      u[k] = (len == 0) ? 0 : (plane_n[k] * 65536) / longint'(len);
      mv[k] = longint'(q.p[k]) - plane_a[k];
      dm[k] = longint'(q.c[k]) - longint'(q.p[k]);
      d += mv[k] * u[k];
      v += dm[k] * u[k];
      push[k] = (u[k] * r) >>> 16;
    end
    d = d >>> 16;
    v = v >>> 16;
    num = (r - d) * 65536;
    if (v == 0) t = (num >= 0) ? SAT_MAX : SAT_MIN;
    else begin
      t = num / v;
      if (t > SAT_MAX) t = SAT_MAX;
      if (t < SAT_MIN) t = SAT_MIN;
    end
    res.hit = 1'b1;
    res.t = coord_t'(t);
    if (v == 0 && (d < 0 ? -d : d) < r) begin
      res.kind = OUT_PARALLEL;
      res.t = coord_t'(SAT_MAX);
      for (int k = 0; k < 3; k++) res.pt[k] = q.p[k];
    end else if ((d < 0 ? -d : d) < r) begin
      res.kind = OUT_PENETRATE;
      for (int k = 0; k < 3; k++) begin
        acc = (128'(signed'(t)) * 128'(signed'(dm[k]))) >>> 16;
        res.pt[k] = clamp32(acc + 128'(signed'(longint'(q.p[k]))));
      end
    end else if (v < 0 && t >= 0 && t <= ONE_Q) begin
      res.kind = OUT_SWEPT;
      for (int k = 0; k < 3; k++) begin
        acc = (128'(signed'(t)) * 128'(signed'(dm[k]))) >>> 16;
        res.pt[k] = clamp32(acc + 128'(signed'(longint'(q.p[k]))) + 128'(signed'(dm[k]))
                            + 128'(signed'(push[k])));
      end
    end else begin
      res.kind = OUT_MISS;
    end
    if (res.kind == OUT_MISS) begin
      res.hit = 1'b0;
      res.t = '0;
      for (int k = 0; k < 3; k++) begin
        res.pt[k] = '0;
        res.push[k] = '0;
      end
    end else begin
      for (int k = 0; k < 3; k++) res.push[k] = clamp32(128'(signed'(push[k])));
    end
    return res;
  endfunction

  task automatic apb_write(reg_idx_e idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 5'(idx) << 2;
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_NORMAL_X: plane_n[0] = longint'(signed'(val));
      REG_NORMAL_Y: plane_n[1] = longint'(signed'(val));
      REG_NORMAL_Z: plane_n[2] = longint'(signed'(val));
      REG_ANCHOR_X: plane_a[0] = longint'(signed'(val));
      REG_ANCHOR_Y: plane_a[1] = longint'(signed'(val));
      REG_ANCHOR_Z: plane_a[2] = longint'(signed'(val));
      default:      plane_r = longint'(val[30:0]);
    endcase
  endtask

  task automatic set_plane(logic [31:0] nx, logic [31:0] ny, logic [31:0] nz,
                           logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
                           logic [31:0] r);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (contact_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    apb_write(REG_NORMAL_X, nx);
    apb_write(REG_NORMAL_Y, ny);
    apb_write(REG_NORMAL_Z, nz);
    apb_write(REG_ANCHOR_X, ax);
    apb_write(REG_ANCHOR_Y, ay);
    apb_write(REG_ANCHOR_Z, az);
    apb_write(REG_RADIUS, r);
  endtask

  task automatic send_query(query_t q, logic typed, contact_t want);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {q.c[2], q.c[1], q.c[0], q.p[2], q.p[1], q.p[0]};
    do @(posedge clk_i); while (!s_axis_tready);
    contact_q.push_back(typed ? want : predict_contact(q));
  endtask

  function automatic coord_t near_coord(longint base, int span);
    return coord_t'(base + longint'($urandom_range(0, 2 * span)) - longint'(span));
  endfunction

  function automatic query_t random_query();
    query_t q;
    int shape;
    shape = $urandom_range(0, 7);
    for (int k = 0; k < 3; k++) begin
      if (shape == 0) begin
        q.p[k] = coord_t'($urandom);
        q.c[k] = coord_t'($urandom);
      end else begin
        q.p[k] = near_coord(plane_a[k], (shape == 1) ? (1 << 24) : (6 << 16));
        q.c[k] = near_coord(longint'(q.p[k]), (shape == 2) ? (1 << 14) : (8 << 16));
      end
    end
    return q;
  endfunction

  task automatic random_burst(int count);
    int left, burst;
    contact_t none;
    left = count;
    none = '{hit: 1'b0, kind: OUT_MISS, t: '0, pt: '{0, 0, 0}, push: '{0, 0, 0}};
    while (left > 0) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst && left > 0; k++, left--) send_query(random_query(), 1'b0, none);
      if ($urandom_range(0, 2) != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  endtask

  always @(posedge clk_i) begin
    contact_t want;
    logic [2:0] tu;
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen <= results_seen + 1;
        if (contact_q.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          want = contact_q.pop_front();
          tu = m_axis_tuser;
          if (tu[0] !== want.hit) report_mismatch("hit", tu[0], want.hit);
          if (tu[2:1] !== want.kind) report_mismatch("outcome", tu[2:1], want.kind);
          if (m_axis_tdata[31:0] !== want.t)
            report_mismatch("hit_time", signed'(m_axis_tdata[31:0]), want.t);
          for (int k = 0; k < 3; k++) begin
            if (m_axis_tdata[32 * (k + 1) +: 32] !== want.pt[k])
              report_mismatch("hit point", signed'(m_axis_tdata[32 * (k + 1) +: 32]),
                              want.pt[k]);
            if (m_axis_tdata[32 * (k + 4) +: 32] !== want.push[k])
              report_mismatch("push", signed'(m_axis_tdata[32 * (k + 4) +: 32]),
                              want.push[k]);
          end
        end
      end
    end
  end

  initial begin
    int span;
    logic held;
    held = 1'b0;
    span = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (!held && results_seen >= 300) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk_i);
      end
      if (span == 0) span = $urandom_range(8, 80);
      span--;
      if (((results_seen / 97) % 3) == 0) m_axis_tready <= 1'b1;
      else m_axis_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  initial begin
    dir_row_t rows[$];
    dir_row_t row;
    contact_t zero_res;
    plane_n = '{0, 0, 65536};
    plane_a = '{0, 0, 0};
    plane_r = 65536;
    zero_res = '{hit: 1'b0, kind: OUT_MISS, t: '0, pt: '{0, 0, 0}, push: '{0, 0, 0}};
    // Resting sphere at the origin: parallel penetration with saturated time.
    row.q = '{p: '{0, 0, 0}, c: '{0, 0, 0}};
    row.typed = 1'b1;
    row.res = '{hit: 1'b1, kind: OUT_PARALLEL, t: 32'sh7fffffff, pt: '{0, 0, 0},
                push: '{0, 0, 65536}};
    rows.push_back(row);
    // Moving away from the plane well above it is a miss.
    row.q = '{p: '{0, 0, 10 << 16}, c: '{0, 0, 20 << 16}};
    row.res = zero_res;
    rows.push_back(row);
    // Swept hit halfway through the motion.
    row.q = '{p: '{0, 0, 2 << 16}, c: '{0, 0, 0}};
    row.res = '{hit: 1'b1, kind: OUT_SWEPT, t: 32'sd32768, pt: '{0, 0, 0},
                push: '{0, 0, 65536}};
    rows.push_back(row);
    row.typed = 1'b0;
    row.q = '{p: '{0, 0, 1 << 15}, c: '{3 << 16, 0, -(1 << 16)}};
    rows.push_back(row);
    row.q = '{p: '{5, 7, 3 << 16}, c: '{5, 7, 3 << 16}};
    rows.push_back(row);
    row.q = '{p: '{1, 2, 4 << 16}, c: '{9, 9, -(4 << 16)}};
    rows.push_back(row);
    row.q = '{p: '{32'sh80000000, 32'sh80000000, 32'sh80000000},
              c: '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff}};
    rows.push_back(row);
    row.q = '{p: '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff},
              c: '{32'sh80000000, 32'sh80000000, 32'sh80000000}};
    rows.push_back(row);
    row.q = '{p: '{0, 0, 32'sh80000000}, c: '{0, 0, 32'sh80000000}};
    rows.push_back(row);
    row.q = '{p: '{0, 0, 32'sh7fffffff}, c: '{-1, -1, 32'sh7fffffff}};
    rows.push_back(row);
    row.q = '{p: '{0, 0, 1 << 16}, c: '{0, 0, 0}};
    rows.push_back(row);
    row.q = '{p: '{0, 0, -(5 << 16)}, c: '{0, 0, -(6 << 16)}};
    rows.push_back(row);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[i]) send_query(rows[i].q, rows[i].typed, rows[i].res);
    random_burst(200);

    set_plane(32'sd65536, 32'sd65536, 32'sd65536, 32'sd65536, -32'sd131072, 32'sd0,
              32'sd131072);
    random_burst(450);
    set_plane($urandom_range(0, 1 << 19) - (1 << 18), $urandom_range(0, 1 << 19) - (1 << 18),
              $urandom_range(0, 1 << 19) - (1 << 18), $urandom, $urandom,
              $urandom_range(0, 1 << 20), $urandom_range(0, 4 << 16));
    random_burst(450);
    set_plane(32'h80000000, 32'h7fffffff, 32'h0, 32'h7fffffff, 32'h80000000, 32'h0,
              32'h7fffffff);
    random_burst(250);
    set_plane(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    random_burst(120);
    set_plane(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'hffffffff);
    random_burst(120);
    set_plane(32'h0, 32'hffffffff, 32'h1, 32'h0, 32'h0, $urandom, 32'h10000);
    random_burst(300);

    s_axis_tvalid <= 1'b0;
    while (contact_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
